// ----- rtl/sdspi_pkg.sv -----
// ----------------------------------------------------------------------------
// sdspi_pkg: shared types and constants for the SD SPI command/response engine
// Holds the exchange phase encoding, the result record, item kinds,
// error codes and the fixed byte values of the SPI-mode protocol.
// ----------------------------------------------------------------------------
package sdspi_pkg;

	// widths fixed by the item fields and the state
	localparam int CMD_W      = 6;
	localparam int ARG_W      = 32;
	localparam int BYTE_W     = 8;
	localparam int WPOS_W     = 6;
	localparam int TRAIL_W    = 5;
	localparam int OKIND_W    = 2;
	localparam int ERR_W      = 2;
	localparam int RES_DEPTH  = 6;
	localparam int RES_CNT_W  = 3;

	// parameter defaults
	localparam int WINDOW_BYTES_DEF    = 32;
	localparam int REG_BLOCK_BYTES_DEF = 16;

	// input item kinds
	localparam logic IN_START = 1'b0;
	localparam logic IN_RXBYTE = 1'b1;

	// result item kinds
	localparam logic [OKIND_W-1:0] OK_FRAME = 2'd0;
	localparam logic [OKIND_W-1:0] OK_R1    = 2'd1;
	localparam logic [OKIND_W-1:0] OK_DATA  = 2'd2;
	localparam logic [OKIND_W-1:0] OK_ERROR = 2'd3;

	// error codes
	localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
	localparam logic [ERR_W-1:0] ERR_NO_RESP  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_NO_TOKEN = 2'd2;
	localparam logic [ERR_W-1:0] ERR_WIN_END  = 2'd3;

	// protocol bytes
	localparam logic [BYTE_W-1:0] START_BITS = 8'h40;
	localparam logic [BYTE_W-1:0] CRC_CMD0   = 8'h95;
	localparam logic [BYTE_W-1:0] CRC_CMD8   = 8'h87;
	localparam logic [BYTE_W-1:0] CRC_OTHER  = 8'h01;
	localparam logic [BYTE_W-1:0] DATA_TOKEN = 8'hFE;
	localparam logic [BYTE_W-1:0] IDLE_BYTE  = 8'hFF;

	// commands with special handling
	localparam logic [CMD_W-1:0] CMD_GO_IDLE   = 6'd0;
	localparam logic [CMD_W-1:0] CMD_SEND_IF   = 6'd8;
	localparam logic [CMD_W-1:0] CMD_SEND_CSD  = 6'd9;
	localparam logic [CMD_W-1:0] CMD_SEND_CID  = 6'd10;
	localparam logic [CMD_W-1:0] CMD_STOP      = 6'd12;
	localparam logic [CMD_W-1:0] CMD_READ_OCR  = 6'd58;

	// short trailer length of R7 and R3
	localparam logic [TRAIL_W-1:0] SHORT_TRAIL = 5'd4;

	// exchange phase
	typedef enum logic [4:0] {
		PH_IDLE  = 5'b00001,
		PH_SCAN  = 5'b00010,
		PH_SKIP  = 5'b00100,
		PH_TOKEN = 5'b01000,
		PH_TRAIL = 5'b10000
	} phase_t;

	// one result item
	typedef struct packed {
		logic [OKIND_W-1:0] kind;
		logic [BYTE_W-1:0]  data;
		logic [ERR_W-1:0]   err;
		logic               last;
	} res_t;

endpackage

// ----- rtl/sd_spi_command_response_engine.sv -----
// ----------------------------------------------------------------------------
// sd_spi_command_response_engine: SD card SPI-mode command and response engine
// Builds the six-byte command frame from a start item and scans received
// bytes for the R1 response, the data token and the trailing bytes.
// ----------------------------------------------------------------------------
//
// channel   dir  tdata (low bit up)                          tuser     tlast
// s_axis    in   cmd_index[5:0] cmd_arg[37:6] rx_byte[45:38]  kind      -
// m_axis    out  out_byte[7:0] error_code[9:8]               out_kind  last
//
// Each input item is decoded combinationally straight into a six-entry result
// register; results leave one per cycle from that register while the output is ready.
// A start item yields six results and so holds the input until the last of them
// leaves; a received byte yields zero to two.
// The next item is taken in the cycle the final pending result leaves.
// Reset clears the phase to idle and empties the result register.
// A stalled output holds its item; the input stalls only behind it.
//
module sd_spi_command_response_engine #(
	parameter int WINDOW_BYTES    = sdspi_pkg::WINDOW_BYTES_DEF,
	parameter int REG_BLOCK_BYTES = sdspi_pkg::REG_BLOCK_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// cmd_index[5:0], cmd_arg[37:6], rx_byte[45:38], zero pad
	input  logic [47:0] s_axis_tdata,
	// kind
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// out_byte[7:0], error_code[9:8], zero pad
	output logic [15:0] m_axis_tdata,
	// out_kind
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast
);

	localparam logic [sdspi_pkg::WPOS_W-1:0]  WIN_END   = sdspi_pkg::WPOS_W'(WINDOW_BYTES);
	localparam logic [sdspi_pkg::TRAIL_W-1:0] REG_TRAIL =
		sdspi_pkg::TRAIL_W'(REG_BLOCK_BYTES);

	// exchange state
	sdspi_pkg::phase_t                   phase_q, phase_d;
	logic [sdspi_pkg::CMD_W-1:0]         cmd_q, cmd_d;
	logic [sdspi_pkg::WPOS_W-1:0]        wpos_q, wpos_d;
	logic [sdspi_pkg::BYTE_W-1:0]        held_q, held_d;
	logic [sdspi_pkg::TRAIL_W-1:0]       trail_q, trail_d;

	// result register
	sdspi_pkg::res_t                     res_q [sdspi_pkg::RES_DEPTH];
	sdspi_pkg::res_t                     res_d [sdspi_pkg::RES_DEPTH];
	logic [sdspi_pkg::RES_CNT_W-1:0]     cnt_q, cnt_d, rd_q;

	// input fields
	logic                                in_kind;
	logic [sdspi_pkg::CMD_W-1:0]         in_cmd;
	logic [sdspi_pkg::ARG_W-1:0]         in_arg;
	logic [sdspi_pkg::BYTE_W-1:0]        in_byte;
	logic                                in_acc, out_acc;
	logic [sdspi_pkg::RES_CNT_W-1:0]     left;

	assign in_kind = s_axis_tuser;
	assign in_cmd  = s_axis_tdata[5:0];
	assign in_arg  = s_axis_tdata[37:6];
	assign in_byte = s_axis_tdata[45:38];

	// handshakes
	assign left          = cnt_q - rd_q;
	assign m_axis_tvalid = (left != '0);
	assign out_acc       = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = (left == '0) || ((left == 3'd1) && m_axis_tready);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// output fields from the current read slot
	assign m_axis_tdata  = {6'd0, res_q[rd_q].err, res_q[rd_q].data};
	assign m_axis_tuser  = res_q[rd_q].kind;
	assign m_axis_tlast  = res_q[rd_q].last;

	// decode of one item
	always_comb begin
		sdspi_pkg::res_t               prim, errr;
		logic                          prim_v, errr_v;
		logic [sdspi_pkg::BYTE_W-1:0]  crc;
		logic [sdspi_pkg::WPOS_W-1:0]  wpos_inc;
		logic [sdspi_pkg::TRAIL_W-1:0] trail_dec;
		logic [sdspi_pkg::TRAIL_W-1:0] tlen;
		phase_d   = phase_q;
		cmd_d     = cmd_q;
		wpos_d    = wpos_q;
		held_d    = held_q;
		trail_d   = trail_q;
		cnt_d     = '0;
		prim      = '0;
		errr      = '0;
		prim_v    = 1'b0;
		errr_v    = 1'b0;
		wpos_inc  = wpos_q + 6'd1;
		trail_dec = (trail_q != '0) ? trail_q - 5'd1 : '0;
		for (int i = 0; i < sdspi_pkg::RES_DEPTH; i++) begin
			res_d[i] = '0;
		end

		// trailer length of the running command
		if ((cmd_q == sdspi_pkg::CMD_SEND_IF) || (cmd_q == sdspi_pkg::CMD_READ_OCR)) begin
			tlen = sdspi_pkg::SHORT_TRAIL;
		end else if ((cmd_q == sdspi_pkg::CMD_SEND_CSD) ||
				(cmd_q == sdspi_pkg::CMD_SEND_CID)) begin
			tlen = REG_TRAIL;
		end else begin
			tlen = '0;
		end

		// frame crc byte
		if (in_cmd == sdspi_pkg::CMD_GO_IDLE) begin
			crc = sdspi_pkg::CRC_CMD0;
		end else if (in_cmd == sdspi_pkg::CMD_SEND_IF) begin
			crc = sdspi_pkg::CRC_CMD8;
		end else begin
			crc = sdspi_pkg::CRC_OTHER;
		end

		if (in_kind == sdspi_pkg::IN_START) begin
			// command frame
			res_d[0] = '{sdspi_pkg::OK_FRAME, sdspi_pkg::START_BITS | {2'b00, in_cmd},
				sdspi_pkg::ERR_NONE, 1'b0};
			res_d[1] = '{sdspi_pkg::OK_FRAME, in_arg[31:24], sdspi_pkg::ERR_NONE, 1'b0};
			res_d[2] = '{sdspi_pkg::OK_FRAME, in_arg[23:16], sdspi_pkg::ERR_NONE, 1'b0};
			res_d[3] = '{sdspi_pkg::OK_FRAME, in_arg[15:8], sdspi_pkg::ERR_NONE, 1'b0};
			res_d[4] = '{sdspi_pkg::OK_FRAME, in_arg[7:0], sdspi_pkg::ERR_NONE, 1'b0};
			res_d[5] = '{sdspi_pkg::OK_FRAME, crc, sdspi_pkg::ERR_NONE, 1'b1};
			cnt_d    = 3'd6;
			cmd_d    = in_cmd;
			phase_d  = sdspi_pkg::PH_SCAN;
			wpos_d   = '0;
			held_d   = sdspi_pkg::IDLE_BYTE;
			trail_d  = '0;
		end else if (phase_q != sdspi_pkg::PH_IDLE) begin
			// per-phase handling of the received byte
			case (phase_q)
				sdspi_pkg::PH_SCAN: begin
					if (in_byte != sdspi_pkg::IDLE_BYTE) begin
						if (cmd_q == sdspi_pkg::CMD_STOP) begin
							held_d  = in_byte;
							phase_d = sdspi_pkg::PH_SKIP;
						end else if (tlen == '0) begin
							prim_v  = 1'b1;
							prim    = '{sdspi_pkg::OK_R1, in_byte, sdspi_pkg::ERR_NONE, 1'b1};
							phase_d = sdspi_pkg::PH_IDLE;
						end else begin
							prim_v  = 1'b1;
							prim    = '{sdspi_pkg::OK_R1, in_byte, sdspi_pkg::ERR_NONE, 1'b0};
							trail_d = tlen;
							phase_d = (tlen == sdspi_pkg::SHORT_TRAIL &&
								cmd_q != sdspi_pkg::CMD_SEND_CSD &&
								cmd_q != sdspi_pkg::CMD_SEND_CID) ?
								sdspi_pkg::PH_TRAIL : sdspi_pkg::PH_TOKEN;
						end
					end
				end
				sdspi_pkg::PH_SKIP: begin
					prim_v  = 1'b1;
					prim    = '{sdspi_pkg::OK_R1,
						(in_byte != sdspi_pkg::IDLE_BYTE) ? in_byte : held_q,
						sdspi_pkg::ERR_NONE, 1'b1};
					phase_d = sdspi_pkg::PH_IDLE;
				end
				sdspi_pkg::PH_TOKEN: begin
					if (in_byte == sdspi_pkg::DATA_TOKEN) begin
						phase_d = sdspi_pkg::PH_TRAIL;
					end
				end
				sdspi_pkg::PH_TRAIL: begin
					prim_v  = 1'b1;
					prim    = '{sdspi_pkg::OK_DATA, in_byte, sdspi_pkg::ERR_NONE,
						trail_dec == '0};
					trail_d = trail_dec;
					if (trail_dec == '0) begin
						phase_d = sdspi_pkg::PH_IDLE;
					end
				end
				default: begin
					phase_d = sdspi_pkg::PH_IDLE;
				end
			endcase

			wpos_d = wpos_inc;

			// window end closes the exchange
			if ((phase_d != sdspi_pkg::PH_IDLE) && (wpos_inc >= WIN_END)) begin
				errr_v = 1'b1;
				case (phase_d)
					sdspi_pkg::PH_SCAN:
						errr = '{sdspi_pkg::OK_ERROR, 8'd0, sdspi_pkg::ERR_NO_RESP, 1'b1};
					sdspi_pkg::PH_SKIP:
						errr = '{sdspi_pkg::OK_R1, held_d, sdspi_pkg::ERR_NONE, 1'b1};
					sdspi_pkg::PH_TOKEN:
						errr = '{sdspi_pkg::OK_ERROR, 8'd0, sdspi_pkg::ERR_NO_TOKEN, 1'b1};
					default:
						errr = '{sdspi_pkg::OK_ERROR, 8'd0, sdspi_pkg::ERR_WIN_END, 1'b1};
				endcase
				phase_d = sdspi_pkg::PH_IDLE;
				trail_d = '0;
			end

			// pack up to two results
			if (prim_v) begin
				res_d[0] = prim;
				res_d[1] = errr;
			end else begin
				res_d[0] = errr;
			end
			cnt_d = {1'b0, prim_v & errr_v, prim_v ^ errr_v};
		end
	end

	// exchange state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sdspi_pkg::PH_IDLE;
			cmd_q   <= '0;
			wpos_q  <= '0;
			held_q  <= sdspi_pkg::IDLE_BYTE;
			trail_q <= '0;
		end else if (in_acc) begin
			phase_q <= phase_d;
			cmd_q   <= cmd_d;
			wpos_q  <= wpos_d;
			held_q  <= held_d;
			trail_q <= trail_d;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else if (in_acc) begin
			cnt_q <= cnt_d;
			rd_q  <= '0;
		end else if (out_acc) begin
			rd_q  <= rd_q + 3'd1;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < sdspi_pkg::RES_DEPTH; i++) begin
				res_q[i] <= res_d[i];
			end
		end
	end

	// checks
	a_rd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_q <= cnt_q) else $error("read slot beyond result count");

	a_phase_hot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q)) else $error("phase not one-hot");

	a_idle_trail: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == sdspi_pkg::PH_IDLE) |-> (trail_q == '0))
		else $error("trailer count left over while idle");

	a_start_six: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_kind == sdspi_pkg::IN_START) |=> (cnt_q == 3'd6 && rd_q == '0))
		else $error("start item did not load a full frame");

	a_rx_two: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_kind == sdspi_pkg::IN_RXBYTE) |=> (cnt_q <= 3'd2))
		else $error("received byte gave more than two results");

endmodule
